/* rtl/nnue_pkg.sv */
package nnue_pkg;

  // default sizes of the network
  localparam int FEATURE_COUNT_DEF = 772;
  localparam int HIDDEN_ONE_DEF    = 256;
  localparam int HIDDEN_TWO_DEF    = 32;
  localparam int WEIGHT_BITS_DEF   = 16;

  // fixed word fields
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 18;
  localparam int VALUE_W    = 16;
  localparam int FEAT_W     = 10;
  localparam int IN_TDATA_W = 48;
  localparam int SCORE_W    = 32;
  localparam int ACC_W      = 32;
  localparam int ACT_W      = 31;
  localparam int SUM_W      = 64;

  localparam logic signed [SUM_W-1:0] SUM_LIMIT = 64'sh4000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] ACT_MAX   = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [SUM_W-1:0] SCORE_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [SUM_W-1:0] SCORE_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEAT_RD,
    ST_FEAT_CHK,
    ST_ROW,
    ST_ROW_LAST,
    ST_L1_RD,
    ST_L1_CALC,
    ST_L2_ISSUE,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_L2,
    ST_OUT_MUL,
    ST_OUT_ACC,
    ST_DONE
  } state_t;

  // control for one cell of the partial-sum ring
  typedef struct packed {
    logic clear;
    logic shift;
    logic add;
  } cell_ctrl_t;

  // add with saturation at +-2^62
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if (s > SUM_LIMIT) return SUM_LIMIT;
    if (s < -SUM_LIMIT) return -SUM_LIMIT;
    return s;
  endfunction

endpackage

/* rtl/nnue_ram.sv */
module nnue_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/nnue_cell.sv */
module nnue_cell (
  input  logic                                      clk,
  input  nnue_pkg::cell_ctrl_t                      ctrl,
  input  logic signed [nnue_pkg::SUM_W-1:0]         sum_in,
  input  logic signed [nnue_pkg::SUM_W-1:0]         addend,
  output logic signed [nnue_pkg::SUM_W-1:0]         sum
);
  import nnue_pkg::*;

  // hold one neuron's partial sum, take the neighbor's on a shift, plus the saturated addend when add is set
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.shift) begin
      sum <= ctrl.add ? sat_add(sum_in, addend) : sum_in;
    end
  end

endmodule

/* rtl/nnue_incremental_evaluator_unit.sv */
// Incremental evaluator for a three-layer network over sparse binary features.
// Each input word carries a command in tuser: weight write, feature mark or
// evaluate. Evaluate walks the features and adds or subtracts one W1 row per
// changed feature, then streams HIDDEN_ONE*HIDDEN_TWO layer-two products
// through a single multiplier into a ring of HIDDEN_TWO partial-sum cells (one
// product per cycle, pausing between layer-one neurons to read and activate the
// next one), then drains the product pipeline and for each output weight reads,
// activates, multiplies and accumulates.
// After reset a clearing pass zeroes the feature sets and the accumulator; no word
// is taken during it.
module nnue_incremental_evaluator_unit #(
  parameter int FEATURE_COUNT = nnue_pkg::FEATURE_COUNT_DEF,
  parameter int HIDDEN_ONE    = nnue_pkg::HIDDEN_ONE_DEF,
  parameter int HIDDEN_TWO    = nnue_pkg::HIDDEN_TWO_DEF,
  parameter int WEIGHT_BITS   = nnue_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // weight_address[17:0], weight_value[33:18], feature_index[43:34], zero fill
  input  logic [nnue_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // command[1:0]
  input  logic [nnue_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // score[31:0]
  output logic [nnue_pkg::SCORE_W-1:0]    m_axis_tdata
);
  import nnue_pkg::*;

  localparam int W1_DEPTH = FEATURE_COUNT * HIDDEN_ONE;
  localparam int W2_DEPTH = HIDDEN_ONE * HIDDEN_TWO;
  localparam int B1_BASE  = W1_DEPTH;
  localparam int W2_BASE  = B1_BASE + HIDDEN_ONE;
  localparam int B2_BASE  = W2_BASE + W2_DEPTH;
  localparam int W3_BASE  = B2_BASE + HIDDEN_TWO;
  localparam int B3_BASE  = W3_BASE + HIDDEN_TWO;
  localparam int FEAT_AW  = $clog2(FEATURE_COUNT);
  localparam int H1_AW    = $clog2(HIDDEN_ONE);
  localparam int H2_AW    = $clog2(HIDDEN_TWO);
  localparam int W1_AW    = $clog2(W1_DEPTH);
  localparam int W2_AW    = $clog2(W2_DEPTH);
  localparam int CLR_N    = (FEATURE_COUNT > HIDDEN_ONE) ? FEATURE_COUNT : HIDDEN_ONE;
  localparam int CLR_AW   = $clog2(CLR_N);
  localparam int PROD_W   = WEIGHT_BITS + 32;

  state_t state, state_next;

  // input word fields
  logic [CMD_W-1:0]          cmd;
  logic [ADDR_W-1:0]         weight_address;
  logic signed [VALUE_W-1:0] weight_value;
  logic [FEAT_W-1:0]         feature_index;
  logic                      in_acc;
  logic [31:0]               addr32;
  logic signed [31:0]        value32;
  logic [WEIGHT_BITS-1:0]    wval;

  assign cmd            = s_axis_tuser;
  assign weight_address = s_axis_tdata[17:0];
  assign weight_value   = s_axis_tdata[33:18];
  assign feature_index  = s_axis_tdata[43:34];
  assign in_acc         = s_axis_tvalid && s_axis_tready;
  assign addr32         = 32'(weight_address);
  assign value32        = 32'(weight_value);
  assign wval           = value32[WEIGHT_BITS-1:0];

  // counters and datapath registers
  logic [CLR_AW-1:0]              clr_cnt;
  logic [FEAT_AW-1:0]             feat_cnt;
  logic [W1_AW-1:0]               w1_base;
  logic [H1_AW-1:0]               hid_cnt;
  logic [H2_AW-1:0]               j_cnt;
  logic [W2_AW-1:0]               w2_addr;
  logic                           row_add;
  logic                           pend;
  logic [H1_AW-1:0]               pend_addr;
  logic [ACT_W-1:0]               l1;
  logic                           iss_v;
  logic [ACT_W-1:0]               iss_l1;
  logic signed [PROD_W-1:0]       prod;
  logic                           prod_v;
  logic [ACT_W-1:0]               l2;
  logic signed [PROD_W-1:0]       oprod;
  logic signed [SUM_W-1:0]        r;
  logic signed [WEIGHT_BITS-1:0]  b3;
  logic [SCORE_W-1:0]             score;

  logic last_feat, last_hid, last_j, clr_last, feat_diff;

  // memory ports
  logic                   w1_we, b1_we, w2_we, b2_we, w3_we, b3_we;
  logic [W1_AW-1:0]       w1_rd_addr;
  logic [WEIGHT_BITS-1:0] w1_q, b1_q, w2_q, b2_q, w3_q;
  logic                   acc_we;
  logic [H1_AW-1:0]       acc_wr_addr;
  logic [ACC_W-1:0]       acc_wr_data, acc_q;
  logic                   cur_we, prev_we;
  logic [FEAT_AW-1:0]     fs_wr_addr;
  logic [0:0]             cur_wr_data, prev_wr_data, cur_q, prev_q;

  cell_ctrl_t              ring_ctrl;
  logic signed [SUM_W-1:0] sums [HIDDEN_TWO];
  logic signed [SUM_W-1:0] addend;

  assign last_feat = feat_cnt == FEAT_AW'(FEATURE_COUNT - 1);
  assign last_hid  = hid_cnt == H1_AW'(HIDDEN_ONE - 1);
  assign last_j    = j_cnt == H2_AW'(HIDDEN_TWO - 1);
  assign clr_last  = clr_cnt == CLR_AW'(CLR_N - 1);
  assign feat_diff = cur_q != prev_q;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (in_acc && cmd == CMD_EVAL) state_next = ST_FEAT_RD;
      ST_FEAT_RD:  state_next = ST_FEAT_CHK;
      ST_FEAT_CHK: begin
        if (feat_diff) state_next = ST_ROW;
        else if (last_feat) state_next = ST_L1_RD;
        else state_next = ST_FEAT_RD;
      end
      ST_ROW:      if (last_hid) state_next = ST_ROW_LAST;
      ST_ROW_LAST: state_next = last_feat ? ST_L1_RD : ST_FEAT_RD;
      ST_L1_RD:    state_next = ST_L1_CALC;
      ST_L1_CALC:  state_next = ST_L2_ISSUE;
      ST_L2_ISSUE: begin
        if (last_j) state_next = last_hid ? ST_DRAIN : ST_L1_RD;
      end
      ST_DRAIN:    if (!iss_v && !prod_v) state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_L2;
      ST_OUT_L2:   state_next = ST_OUT_MUL;
      ST_OUT_MUL:  state_next = ST_OUT_ACC;
      ST_OUT_ACC:  state_next = last_j ? ST_DONE : ST_OUT_RD;
      ST_DONE:     if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // outputs: handshake, memory ports and ring control
  always_comb begin
    s_axis_tready = state == ST_IDLE;
    w1_we = 1'b0; b1_we = 1'b0; w2_we = 1'b0;
    b2_we = 1'b0; w3_we = 1'b0; b3_we = 1'b0;
    cur_we = 1'b0; prev_we = 1'b0;
    fs_wr_addr   = feat_cnt;
    cur_wr_data  = 1'b0;
    prev_wr_data = 1'b0;
    acc_we       = pend;
    acc_wr_addr  = pend_addr;
    acc_wr_data  = row_add ? acc_q + ACC_W'($signed(w1_q)) : acc_q - ACC_W'($signed(w1_q));
    w1_rd_addr   = w1_base + W1_AW'(hid_cnt);
    ring_ctrl.clear = 1'b0;
    ring_ctrl.shift = prod_v || state == ST_OUT_ACC;
    ring_ctrl.add   = prod_v;
    unique case (state)
      ST_CLEAR: begin
        cur_we       = 32'(clr_cnt) < FEATURE_COUNT;
        prev_we      = cur_we;
        fs_wr_addr   = FEAT_AW'(clr_cnt);
        acc_we       = 32'(clr_cnt) < HIDDEN_ONE;
        acc_wr_addr  = H1_AW'(clr_cnt);
        acc_wr_data  = '0;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_WRITE: begin
              w1_we = addr32 < B1_BASE;
              b1_we = addr32 >= B1_BASE && addr32 < W2_BASE;
              w2_we = addr32 >= W2_BASE && addr32 < B2_BASE;
              b2_we = addr32 >= B2_BASE && addr32 < W3_BASE;
              w3_we = addr32 >= W3_BASE && addr32 < B3_BASE;
              b3_we = addr32 == B3_BASE;
            end
            CMD_MARK: begin
              cur_we      = 32'(feature_index) < FEATURE_COUNT;
              fs_wr_addr  = FEAT_AW'(feature_index);
              cur_wr_data = 1'b1;
            end
            CMD_EVAL: ring_ctrl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FEAT_CHK: begin
        // current set becomes previous, current is cleared
        cur_we       = 1'b1;
        prev_we      = 1'b1;
        prev_wr_data = cur_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      pend          <= 1'b0;
      iss_v         <= 1'b0;
      prod_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      pend   <= state == ST_ROW;
      iss_v  <= state == ST_L2_ISSUE;
      prod_v <= iss_v;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pend_addr <= hid_cnt;
    iss_l1    <= l1;
    prod      <= $signed(w2_q) * $signed({1'b0, iss_l1});
    if (b3_we) b3 <= wval;
    unique case (state)
      ST_IDLE: begin
        feat_cnt <= '0;
        w1_base  <= '0;
      end
      ST_FEAT_CHK: begin
        hid_cnt <= '0;
        row_add <= cur_q[0];
        w2_addr <= '0;
        if (!feat_diff && !last_feat) begin
          feat_cnt <= feat_cnt + 1'b1;
          w1_base  <= w1_base + W1_AW'(HIDDEN_ONE);
        end
      end
      ST_ROW: if (!last_hid) hid_cnt <= hid_cnt + 1'b1;
      ST_ROW_LAST: begin
        hid_cnt <= '0;
        w2_addr <= '0;
        if (!last_feat) begin
          feat_cnt <= feat_cnt + 1'b1;
          w1_base  <= w1_base + W1_AW'(HIDDEN_ONE);
        end
      end
      ST_L1_CALC: begin
        // bias, relu and clamp of one layer-one neuron
        logic signed [ACC_W:0] a;
        a = (ACC_W+1)'($signed(acc_q)) + (ACC_W+1)'($signed(b1_q));
        if (a < 0) l1 <= '0;
        else if (a > (ACC_W+1)'(ACT_MAX)) l1 <= '1;
        else l1 <= a[ACT_W-1:0];
        j_cnt <= '0;
      end
      ST_L2_ISSUE: begin
        w2_addr <= w2_addr + 1'b1;
        if (last_j) begin
          j_cnt <= '0;
          if (!last_hid) hid_cnt <= hid_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        j_cnt <= '0;
        r     <= SUM_W'(b3);
      end
      ST_OUT_L2: begin
        logic signed [SUM_W-1:0] s;
        s = sat_add(sums[0], SUM_W'($signed(b2_q)));
        if (s < 0) l2 <= '0;
        else if (s > ACT_MAX) l2 <= '1;
        else l2 <= s[ACT_W-1:0];
      end
      ST_OUT_MUL: oprod <= $signed(w3_q) * $signed({1'b0, l2});
      ST_OUT_ACC: begin
        r     <= sat_add(r, SUM_W'(oprod >>> 8));
        j_cnt <= last_j ? '0 : j_cnt + 1'b1;
      end
      ST_DONE: begin
        // truncate toward zero, saturate to 32 bits, only once the output is free
        logic signed [SUM_W-1:0] t;
        t = (r >= 0) ? (r >>> 8) : -((-r) >>> 8);
        if (!m_axis_tvalid || m_axis_tready) begin
          if (t > SCORE_MAX) score <= SCORE_MAX[SCORE_W-1:0];
          else if (t < SCORE_MIN) score <= SCORE_MIN[SCORE_W-1:0];
          else score <= t[SCORE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = score;
  assign addend       = SUM_W'(prod >>> 8);

  // weight stores
  nnue_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W1_DEPTH)) u_w1 (
    .clk(clk), .wr_en(w1_we), .wr_addr(W1_AW'(addr32)), .wr_data(wval),
    .rd_addr(w1_rd_addr), .rd_data(w1_q));
  nnue_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(HIDDEN_ONE)) u_b1 (
    .clk(clk), .wr_en(b1_we), .wr_addr(H1_AW'(addr32 - B1_BASE)), .wr_data(wval),
    .rd_addr(hid_cnt), .rd_data(b1_q));
  nnue_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W2_DEPTH)) u_w2 (
    .clk(clk), .wr_en(w2_we), .wr_addr(W2_AW'(addr32 - W2_BASE)), .wr_data(wval),
    .rd_addr(w2_addr), .rd_data(w2_q));
  nnue_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(HIDDEN_TWO)) u_b2 (
    .clk(clk), .wr_en(b2_we), .wr_addr(H2_AW'(addr32 - B2_BASE)), .wr_data(wval),
    .rd_addr(j_cnt), .rd_data(b2_q));
  nnue_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(HIDDEN_TWO)) u_w3 (
    .clk(clk), .wr_en(w3_we), .wr_addr(H2_AW'(addr32 - W3_BASE)), .wr_data(wval),
    .rd_addr(j_cnt), .rd_data(w3_q));

  // accumulator and feature sets
  nnue_ram #(.WIDTH(ACC_W), .DEPTH(HIDDEN_ONE)) u_acc (
    .clk(clk), .wr_en(acc_we), .wr_addr(acc_wr_addr), .wr_data(acc_wr_data),
    .rd_addr(hid_cnt), .rd_data(acc_q));
  nnue_ram #(.WIDTH(1), .DEPTH(FEATURE_COUNT)) u_cur (
    .clk(clk), .wr_en(cur_we), .wr_addr(fs_wr_addr), .wr_data(cur_wr_data),
    .rd_addr(feat_cnt), .rd_data(cur_q));
  nnue_ram #(.WIDTH(1), .DEPTH(FEATURE_COUNT)) u_prev (
    .clk(clk), .wr_en(prev_we), .wr_addr(fs_wr_addr), .wr_data(prev_wr_data),
    .rd_addr(feat_cnt), .rd_data(prev_q));

  // ring of layer-two partial sums, products enter at the tail
  for (genvar n = 0; n < HIDDEN_TWO; n++) begin : g_cell
    cell_ctrl_t cc;
    assign cc.clear = ring_ctrl.clear;
    assign cc.shift = ring_ctrl.shift;
    assign cc.add   = ring_ctrl.add && (n == HIDDEN_TWO - 1);
    nnue_cell u_cell (
      .clk(clk), .ctrl(cc),
      .sum_in(sums[(n + 1) % HIDDEN_TWO]), .addend(addend), .sum(sums[n]));
  end

`ifndef SYNTH
  a_pend_after_row: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(state) == ST_ROW) else $error("accumulator write outside row walk");
  a_prod_after_issue: assert property (@(posedge clk) disable iff (rst)
    prod_v |-> $past(iss_v)) else $error("product without issue");
  a_out_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT_RD |-> !iss_v && !prod_v) else $error("output phase before drain");
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_DONE) else $error("score not from done");
`endif

endmodule
